@@ rtl/core/mrcrc_pkg.sv @@
// Package for the Modbus RTU frame CRC appender.
// Holds the CRC constants, the emit phase type and the item struct.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none
package mrcrc_pkg;

    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_START_RESET = 16'hFFFF;
    localparam int unsigned CFG_ADDR_W      = 3;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_LOW,
        EMIT_HIGH
    } emit_phase_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc;
    } item_t;

endpackage
`default_nettype wire

@@ rtl/core/modbus_rtu_frame_crc_appender_top.sv @@
// Top level of the Modbus RTU frame CRC appender: configuration register,
// running CRC and frame tracking. Uses mrcrc_pkg, mrcrc_fold, mrcrc_emit.
`default_nettype none
// Each accepted word is passed through in the next cycle and folded into a
// reflected CRC-16 (polynomial 0xA001). After a word marked last, the CRC
// low and then high byte follow, the high byte marked last. Ordinary words
// are taken one per cycle while the output is not stalled; after a last
// word the input holds off while the single result register sends the
// CRC bytes. Each frame starts from crc_start_value (register 0, reset
// 0xFFFF for Modbus; 0x0000 gives CRC-16/ARC); a new value written in the
// middle of a frame takes effect from the next frame.
module modbus_rtu_frame_crc_appender_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_in_byte,
    input  wire logic                              s_in_last,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [7:0]                        m_out_byte,
    output logic                                   m_out_last,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mrcrc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);

    logic [15:0] start_reg, start_next;
    logic [15:0] acc_reg, acc_next;
    logic        in_frame_reg, in_frame_next;
    logic [15:0] crc_src;
    logic [15:0] crc_folded;
    logic        cfg_hit;
    logic        s_accept;
    mrcrc_pkg::item_t item;

    assign pready   = 1'b1;
    assign cfg_hit  = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {16'h0000, start_reg} : 32'h0000_0000;
    assign s_accept = s_valid && s_ready;
    assign crc_src  = in_frame_reg ? acc_reg : start_reg;

    mrcrc_fold u_fold (
        .crc_in  (crc_src),
        .data_in (s_in_byte),
        .crc_out (crc_folded)
    );

    always_comb begin
        item.data = s_in_byte;
        item.last = s_in_last;
        item.crc  = crc_folded;
    end

    always_comb begin
        start_next    = cfg_hit ? pwdata[15:0] : start_reg;
        acc_next      = acc_reg;
        in_frame_next = in_frame_reg;
        if (s_accept) begin
            acc_next      = crc_folded;
            in_frame_next = !s_in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg    <= mrcrc_pkg::CRC_START_RESET;
            acc_reg      <= mrcrc_pkg::CRC_START_RESET;
            in_frame_reg <= 1'b0;
        end else begin
            start_reg    <= start_next;
            acc_reg      <= acc_next;
            in_frame_reg <= in_frame_next;
        end
    end

    mrcrc_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_byte  (m_out_byte),
        .out_last  (m_out_last)
    );

endmodule
`default_nettype wire

@@ rtl/core/mrcrc_fold.sv @@
// Folds one byte into a reflected CRC-16, eight shift steps LSB first.
// Purely combinational; depends on mrcrc_pkg for the polynomial.
`default_nettype none
module mrcrc_fold (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mrcrc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule
`default_nettype wire

@@ rtl/core/mrcrc_emit.sv @@
// Result register and emit sequencer: passes each word out, then appends
// the CRC low and high bytes after a last word. Depends on mrcrc_pkg.
`default_nettype none
module mrcrc_emit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mrcrc_pkg::item_t in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [7:0]       out_byte,
    output logic                  out_last
);

    mrcrc_pkg::emit_phase_t phase_reg, phase_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic [15:0] crc_reg, crc_next;
    logic        load_ok;
    logic        in_accept;

    assign load_ok   = !out_valid_reg || out_ready;
    assign in_ready  = (phase_reg == mrcrc_pkg::EMIT_NONE) && load_ok;
    assign in_accept = in_valid && in_ready;
    assign crc_next  = (in_accept && in_item.last) ? in_item.crc : crc_reg;

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            mrcrc_pkg::EMIT_NONE: begin
                if (in_accept && in_item.last) begin
                    phase_next = mrcrc_pkg::EMIT_LOW;
                end
            end
            mrcrc_pkg::EMIT_LOW: begin
                if (load_ok) begin
                    phase_next = mrcrc_pkg::EMIT_HIGH;
                end
            end
            mrcrc_pkg::EMIT_HIGH: begin
                if (load_ok) begin
                    phase_next = mrcrc_pkg::EMIT_NONE;
                end
            end
            default: phase_next = mrcrc_pkg::EMIT_NONE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        case (phase_reg)
            mrcrc_pkg::EMIT_NONE: begin
                if (in_accept) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = in_item.data;
                    out_last_next  = 1'b0;
                end else if (out_valid_reg && out_ready) begin
                    out_valid_next = 1'b0;
                end
            end
            mrcrc_pkg::EMIT_LOW: begin
                if (load_ok) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_reg[7:0];
                    out_last_next  = 1'b0;
                end
            end
            mrcrc_pkg::EMIT_HIGH: begin
                if (load_ok) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_reg[15:8];
                    out_last_next  = 1'b1;
                end
            end
            default: out_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= mrcrc_pkg::EMIT_NONE;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        crc_reg      <= crc_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // While CRC bytes are pending, a word is always held at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != mrcrc_pkg::EMIT_NONE) |-> out_valid_reg)
        else $error("CRC pending with empty output register");

    // A last word is always followed by the CRC low byte phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_item.last) |=> (phase_reg == mrcrc_pkg::EMIT_LOW))
        else $error("last word did not start CRC emission");

    // The high byte goes out marked as the end of the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == mrcrc_pkg::EMIT_HIGH && out_ready)
        |=> (out_valid_reg && out_last_reg && phase_reg == mrcrc_pkg::EMIT_NONE))
        else $error("CRC high byte not marked last");

    // A word marked last is never shown while CRC bytes are still pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |-> (phase_reg == mrcrc_pkg::EMIT_NONE))
        else $error("frame end shown before CRC complete");

endmodule
`default_nettype wire

@@ dv/tb_modbus_rtu_frame_crc_appender_top.sv @@
// Testbench for modbus_rtu_frame_crc_appender_top: directed frames with known CRCs, then
// random frames with random idling, checked word by word against a CRC-16 predictor.
// Depends on mrcrc_pkg and the RTL top level; needs no files or arguments.
module tb_modbus_rtu_frame_crc_appender_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W = mrcrc_pkg::CFG_ADDR_W;
    localparam bit [1:0] REG_CRC_START = 2'd0;
    localparam bit [1:0] REG_UNMAPPED = 2'd1;
    localparam int N_DIRECTED = 22;
    localparam int RANDOM_WORDS = 200;
    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_word_t;

    typedef struct packed {
        bit        cfg_en;
        bit [1:0]  cfg_idx;
        bit [15:0] cfg_val;
        bit [7:0]  data;
        bit        last;
        bit        crc_known;
        bit [15:0] crc;
    } dir_row_t;

    dir_row_t dir_rows [N_DIRECTED] = '{
        '{1'b0, REG_CRC_START, 16'h0000, 8'h31, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h32, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h33, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h34, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h35, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h36, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h37, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h38, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h39, 1'b1, 1'b1, 16'h4B37},
        '{1'b1, REG_CRC_START, 16'h0000, 8'h00, 1'b1, 1'b1, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'hFF, 1'b1, 1'b0, 16'h0000},
        '{1'b1, REG_CRC_START, 16'hFFFF, 8'h00, 1'b0, 1'b0, 16'h0000},
        '{1'b1, REG_CRC_START, 16'h0000, 8'hFF, 1'b1, 1'b0, 16'h0000},
        '{1'b1, REG_UNMAPPED,  16'hFFFF, 8'h31, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h32, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h33, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h34, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h35, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h36, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h37, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h38, 1'b0, 1'b0, 16'h0000},
        '{1'b0, REG_CRC_START, 16'h0000, 8'h39, 1'b1, 1'b1, 16'hBB3D}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_in_byte;
    logic              s_in_last;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_out_byte;
    logic              m_out_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    logic [15:0] crc_start;
    logic [15:0] crc_running;
    logic        frame_open;
    out_word_t   frame_words_due [$];
    int          n_errors = 0;
    int          words_sent = 0;
    bit          hold_req = 1'b0;

    modbus_rtu_frame_crc_appender_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ mrcrc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void predict_frame_word(input logic [7:0] b, input logic l,
                                               input bit crc_known, input logic [15:0] crc_typed);
        logic [15:0] crc;
        crc = crc16_fold(frame_open ? crc_running : crc_start, b);
        frame_words_due.push_back('{data: b, last: 1'b0});
        if (l) begin
            if (crc_known) begin
                crc = crc_typed;
            end
            frame_words_due.push_back('{data: crc[7:0], last: 1'b0});
            frame_words_due.push_back('{data: crc[15:8], last: 1'b1});
            crc_running = crc_start;
            frame_open = 1'b0;
        end else begin
            crc_running = crc;
            frame_open = 1'b1;
        end
    endfunction

    function automatic logic [15:0] pick_start_value();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) begin
            return 16'h0000;
        end else if (r == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_word(input logic [7:0] b, input logic l, input bit burst,
                             input bit crc_known, input logic [15:0] crc_typed);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_in_last <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_frame_word(b, l, crc_known, crc_typed);
        words_sent++;
    endtask

    task automatic drain_frame_words();
        s_valid <= 1'b0;
        while (frame_words_due.size() != 0) @(posedge aclk);
    endtask

    // The block is drained first, then the register is written and the start
    // value read back.
    task automatic write_config_reg(input logic [1:0] idx, input logic [15:0] val);
        drain_frame_words();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= {16'h0000, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_CRC_START) begin
            crc_start = val;
            if (!frame_open) begin
                crc_running = val;
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= ADDR_W'(4 * REG_CRC_START);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {16'h0000, crc_start}) begin
            $error("prdata: expected %h, actual %h", {16'h0000, crc_start}, prdata);
            n_errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin : check_out
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_words_due.size() == 0) begin
                $error("unexpected word: out_byte %h, out_last %b", m_out_byte, m_out_last);
                n_errors++;
            end else begin
                want = frame_words_due.pop_front();
                if (m_out_byte !== want.data) begin
                    $error("out_byte: expected %h, actual %h", want.data, m_out_byte);
                    n_errors++;
                end
                if (m_out_last !== want.last) begin
                    $error("out_last: expected %b, actual %b", want.last, m_out_last);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int gap;
        int got;
        bit burst_rx;
        m_ready = 1'b0;
        got = 0;
        burst_rx = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (got % 24 == 0) begin
                burst_rx = ($urandom_range(0, 2) == 0);
            end
            gap = hold_req ? HOLD_CYCLES : (burst_rx ? 0 : $urandom_range(0, 6));
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            hold_req = 1'b0;
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got++;
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int len;
        int frames;
        int r;
        bit burst;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_in_last = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'h0;
        crc_start = mrcrc_pkg::CRC_START_RESET;
        crc_running = mrcrc_pkg::CRC_START_RESET;
        frame_open = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (dir_rows[i].cfg_en) begin
                write_config_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
            end
            send_word(dir_rows[i].data, dir_rows[i].last, 1'b0,
                      dir_rows[i].crc_known, dir_rows[i].crc);
        end

        frames = 0;
        while (words_sent < N_DIRECTED + RANDOM_WORDS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
            burst = ($urandom_range(0, 3) == 0);
            // A long back-to-back frame against a stalled receiver fills the block.
            if (frames == 8) begin
                len = 16;
                burst = 1'b1;
                hold_req = 1'b1;
            end
            for (int i = 0; i < len; i++) begin
                if (i == len / 2 && i > 0 && $urandom_range(0, 5) == 0) begin
                    write_config_reg(REG_CRC_START, pick_start_value());
                end
                send_word(8'($urandom_range(0, 255)), i == len - 1, burst, 1'b0, 16'h0000);
            end
            r = $urandom_range(0, 7);
            if (r == 0) begin
                write_config_reg(REG_CRC_START, pick_start_value());
            end else if (r == 1) begin
                write_config_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
            end
            if (frames == 20) begin
                drain_frame_words();
            end
            frames++;
        end

        drain_frame_words();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
